[rtl/ermt_pkg.sv]
package ermt_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 4;

    // Longest extent that an add request may carry
    localparam logic [15:0] MAX_EXTENT_LEN = 16'd32768;

    // Request kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] logical_block;
        logic [31:0] physical_block;
        logic [15:0] extent_length;
    } ermt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] mapped_block;
    } ermt_out_t;

    typedef struct packed {
        logic [31:0] logical_start;
        logic [31:0] physical_start;
        logic [15:0] block_count;
    } ermt_extent_t;

endpackage

[rtl/ermt_table.sv]
module ermt_table import ermt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  ermt_extent_t       wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output ermt_extent_t       rd_data
);

    ermt_extent_t mem [TABLE_ENTRIES];
    ermt_extent_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/extent_range_map_table_top.sv]
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   ermt_in_t  (kind, blocks, length)
// m_        out        m_valid / m_ready   ermt_out_t (status, found, mapped_block)
//
// Clear and add requests go from accept through S_DONE into the output register.
// A lookup steps S_READ then S_CMP for each scanned extent (then S_ADD on a hit): each extent
// needs one read of the extent memory and one pass through the shared
// adder for the subtract/compare; a hit adds one more pass on the same adder.
// One request is in flight at a time; s_ready drops from accept until the
// result moves into the output register.
// aresetn is synchronous, active low, and empties the table.
// A stalled result holds in the output register; a finished request waits
// in its last state until that register is free.
module extent_range_map_table_top import ermt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ermt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ermt_out_t m_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             m_valid_reg, m_valid_next;
    ermt_out_t        m_data_reg, m_data_next;
    ermt_out_t        res_reg, res_next;
    logic [31:0]      query_reg, query_next;
    logic [15:0]      offset_reg, offset_next;

    logic             s_accept;
    logic             out_free;
    logic             table_full;
    logic             wr_en;
    logic             rd_en;
    ermt_extent_t     wr_data;
    ermt_extent_t     rd_data;
    logic             add_phase;
    logic [31:0]      alu_a;
    logic [31:0]      alu_b;
    logic             alu_cin;
    logic [32:0]      alu_sum;
    logic             hit;
    logic             last_entry;

    ermt_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign table_full = (count_reg >= CNT_W'(TABLE_ENTRIES));

    assign wr_data.logical_start  = s_data.logical_block;
    assign wr_data.physical_start = s_data.physical_block;
    assign wr_data.block_count    = s_data.extent_length;

    // Shared adder: query minus extent start while comparing, physical start
    // plus offset on a hit; carry out on the subtract means no borrow
    assign add_phase = (state_reg == S_ADD);
    assign alu_a     = add_phase ? rd_data.physical_start : query_reg;
    assign alu_b     = add_phase ? {16'd0, offset_reg} : ~rd_data.logical_start;
    assign alu_cin   = !add_phase;
    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_cin};

    assign hit        = alu_sum[32] && (rd_data.block_count != 16'd0)
                        && (alu_sum[31:0] < {16'd0, rd_data.block_count});
    assign last_entry = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        query_next   = query_reg;
        offset_next  = offset_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    query_next            = s_data.logical_block;
                    res_next.status       = STATUS_OK;
                    res_next.found        = 1'b0;
                    res_next.mapped_block = 32'd0;
                    state_next            = S_DONE;
                    case (s_data.kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                        end
                        KIND_ADD: begin
                            if (table_full) begin
                                res_next.status = STATUS_FULL;
                            end else if (s_data.extent_length > MAX_EXTENT_LEN) begin
                                res_next.status = STATUS_TOO_LONG;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_LOOKUP: begin
                            if (count_reg != '0) begin
                                scan_next  = '0;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                rd_en      = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    offset_next = alu_sum[15:0];
                    state_next  = S_ADD;
                end else if (last_entry) begin
                    state_next = S_DONE;
                end else begin
                    scan_next  = scan_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_ADD: begin
                res_next.found        = 1'b1;
                res_next.mapped_block = alu_sum[31:0];
                state_next            = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        query_reg  <= query_next;
        offset_reg <= offset_next;
    end

endmodule

[rtl/ermt_checker.sv]
module ermt_checker import ermt_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input ermt_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input ermt_out_t m_data
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // One request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // A hit is always reported with status ok
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.status == STATUS_OK)
        else $error("hit with error status");

    // A miss or non-lookup result carries no block
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.mapped_block == 32'd0)
        else $error("nonzero block without a hit");

endmodule

bind extent_range_map_table_top ermt_checker u_ermt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/sv/extent_range_map_table_top_tb.sv]
`timescale 1ns / 100ps

module extent_range_map_table_top_tb;
    import ermt_pkg::*;

    localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    class extent_map_checker;
        ermt_extent_t extents[TABLE_DEPTH];
        int unsigned  stored;
        ermt_out_t    expected_maps[$];
        int unsigned  mismatch_count;

        function new();
            stored = 0;
            mismatch_count = 0;
            foreach (extents[i]) extents[i] = '0;
        endfunction

        function void note_request(ermt_in_t req);
            ermt_out_t   res;
            logic [31:0] offset;
            res = '0;
            case (req.kind)
                KIND_CLEAR: begin
                    stored = 0;
                end
                KIND_ADD: begin
                    // full table wins over the length check
                    if (stored >= TABLE_DEPTH) begin
                        res.status = STATUS_FULL;
                    end else if (req.extent_length > MAX_EXTENT_LEN) begin
                        res.status = STATUS_TOO_LONG;
                    end else begin
                        extents[stored] = '{req.logical_block, req.physical_block,
                                            req.extent_length};
                        stored++;
                    end
                end
                KIND_LOOKUP: begin
                    // first hit in insertion order; skip empty extents
                    for (int i = 0; i < stored && !res.found; i++) begin
                        offset = req.logical_block - extents[i].logical_start;
                        if (extents[i].block_count != 0 &&
                            req.logical_block >= extents[i].logical_start &&
                            offset < extents[i].block_count) begin
                            res.found = 1'b1;
                            res.mapped_block = extents[i].physical_start + offset;
                        end
                    end
                end
                default: ;
            endcase
            expected_maps.push_back(res);
        endfunction

        function void check_result(ermt_out_t got);
            ermt_out_t want;
            if (expected_maps.size() == 0) begin
                $error("unexpected result: status %0d found %0d mapped_block 0x%08h",
                       got.status, got.found, got.mapped_block);
                mismatch_count++;
                return;
            end
            want = expected_maps.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatch_count++;
            end
            if (got.mapped_block !== want.mapped_block) begin
                $error("mapped_block: expected 0x%08h, actual 0x%08h",
                       want.mapped_block, got.mapped_block);
                mismatch_count++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ermt_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ermt_out_t m_data;

    int send_idle_pct = 26;
    int recv_idle_pct = 46;
    int cycle_count = 0;

    extent_map_checker map_checker;

    extent_range_map_table_top #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            map_checker.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("extent_range_map_table_top: mismatch");
            $finish;
        end
    end

    function automatic ermt_in_t make_request(logic [1:0] kind, logic [31:0] lblk,
                                              logic [31:0] pblk, logic [15:0] len);
        ermt_in_t req;
        req.kind = kind;
        req.logical_block = lblk;
        req.physical_block = pblk;
        req.extent_length = len;
        return req;
    endfunction

    // Hold valid and payload until the block takes the request.
    task automatic send_request(ermt_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        map_checker.note_request(req);
    endtask

    task automatic run_directed();
        // empty table
        send_request(make_request(KIND_LOOKUP, 32'd0, 32'd0, 16'd0));
        // physical range wraps past the top
        send_request(make_request(KIND_ADD, 32'd0, 32'hFFFF_FFF0, 16'd32));
        // longest legal extent, ending at the last logical block
        send_request(make_request(KIND_ADD, 32'hFFFF_8000, 32'h0000_1000, 16'd32768));
        send_request(make_request(KIND_ADD, 32'd500, 32'd1, 16'd32769));
        send_request(make_request(KIND_ADD, 32'd500, 32'd1, 16'hFFFF));
        send_request(make_request(KIND_ADD, 32'd100, 32'd5, 16'd0));
        // overlaps the first extent, which must still win
        send_request(make_request(KIND_ADD, 32'd10, 32'hABCD_0000, 16'd5));
        send_request(make_request(KIND_ADD, 32'd200, 32'd7, 16'hFFFF));
        send_request(make_request(KIND_ADD, 32'd200, 32'd7, 16'd1));
        send_request(make_request(KIND_LOOKUP, 32'd0, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(KIND_LOOKUP, 32'd31, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'd32, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'd12, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'd100, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_8000, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_7FFF, 32'd0, 16'd0));
        send_request(make_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_request(KIND_LOOKUP, 32'd0, 32'd0, 16'd0));
        send_request(make_request(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 16'd0));
        send_request(make_request(KIND_LOOKUP, 32'd0, 32'd0, 16'd0));
        send_request(make_request(KIND_CLEAR, 32'd0, 32'd0, 16'd0));
    endtask

    task automatic run_random(int request_goal);
        int          issued;
        int          add_total;
        int          lookup_total;
        int          pick;
        int          sel;
        logic [31:0] lblk;
        logic [31:0] pblk;
        logic [15:0] len;
        ermt_extent_t ext;
        issued = 0;
        while (issued < request_goal) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 60) begin
                    send_request(make_request(KIND_CLEAR, $urandom, $urandom,
                                              16'($urandom)));
                    issued++;
                end
                add_total = $urandom_range(1, 5);
                for (int a = 0; a < add_total; a++) begin
                    sel = $urandom_range(99);
                    if (sel < 8)        len = 16'd0;
                    else if (sel < 14)  len = 16'd32768;
                    else if (sel < 20)  len = 16'($urandom_range(32769, 65535));
                    else if (sel < 35)  len = 16'($urandom_range(1, 32768));
                    else                len = 16'($urandom_range(1, 64));
                    sel = $urandom_range(99);
                    if (sel < 25 && map_checker.stored > 0) begin
                        pick = $urandom_range(0, map_checker.stored - 1);
                        lblk = map_checker.extents[pick].logical_start
                               + $urandom_range(0, 8);
                    end else if (sel < 35) begin
                        lblk = 32'hFFFF_FFFF - $urandom_range(0, 100);
                    end else begin
                        lblk = $urandom;
                    end
                    pblk = ($urandom_range(99) < 15) ? 32'hFFFF_FFFF - $urandom_range(0, 100)
                                                     : $urandom;
                    send_request(make_request(KIND_ADD, lblk, pblk, len));
                    issued++;
                end
                lookup_total = $urandom_range(2, 8);
                for (int q = 0; q < lookup_total; q++) begin
                    if (map_checker.stored > 0 && $urandom_range(99) < 75) begin
                        pick = $urandom_range(0, map_checker.stored - 1);
                        ext = map_checker.extents[pick];
                        case ($urandom_range(4))
                            0: lblk = ext.logical_start;
                            1: lblk = ext.logical_start + ext.block_count - 1;
                            2: lblk = ext.logical_start + ext.block_count;
                            3: lblk = ext.logical_start - 1;
                            default: lblk = ext.logical_start
                                            + $urandom_range(0, ext.block_count);
                        endcase
                    end else begin
                        lblk = $urandom;
                    end
                    send_request(make_request(KIND_LOOKUP, lblk, $urandom,
                                              16'($urandom)));
                    issued++;
                end
            end else begin
                // noise: any kind, any field
                sel = $urandom_range(3);
                send_request(make_request(2'(sel), $urandom, $urandom, 16'($urandom)));
                if (sel != 3) issued++;
            end
        end
    endtask

    initial begin
        map_checker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 26;
        recv_idle_pct = 46;
        run_directed();
        run_random(470);

        send_idle_pct = 46;
        recv_idle_pct = 26;
        run_random(470);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(470);

        s_valid <= 1'b0;
        while (map_checker.expected_maps.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (map_checker.mismatch_count == 0) begin
            $display("extent_range_map_table_top: match");
        end else begin
            $display("extent_range_map_table_top: mismatch");
        end
        $finish;
    end

endmodule
